>>> src/atsf_pkg.sv
package atsf_pkg;

    // Number of filter keys the block compares; only the first four registers exist
    localparam int MAX_FILTER_KEYS = 4;
    localparam int NUM_KEY_REGS    = 4;
    localparam int MAX_RESULTS     = 3;

    localparam int KEY_W   = 16;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_TDATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_D     = 3'd4;

    // Register reset values
    localparam logic [2:0]       KEY_COUNT_RST = 3'd1;
    localparam logic [KEY_W-1:0] KEY_A_RST     = 16'd21063;

    // Summary status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // Result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Type characters
    localparam logic [7:0] CH_UA = 8'h41; // 'A'
    localparam logic [7:0] CH_UC = 8'h43; // 'C'
    localparam logic [7:0] CH_LC = 8'h63; // 'c'
    localparam logic [7:0] CH_US = 8'h53; // 'S'
    localparam logic [7:0] CH_LS = 8'h73; // 's'
    localparam logic [7:0] CH_UI = 8'h49; // 'I'
    localparam logic [7:0] CH_LI = 8'h69; // 'i'
    localparam logic [7:0] CH_LF = 8'h66; // 'f'
    localparam logic [7:0] CH_LD = 8'h64; // 'd'
    localparam logic [7:0] CH_UZ = 8'h5A; // 'Z'
    localparam logic [7:0] CH_UH = 8'h48; // 'H'

    // Payload size codes
    localparam logic [3:0] SIZE_UNKNOWN = 4'd0;
    localparam logic [3:0] SIZE_STRING  = 4'd15;

    typedef enum logic [5:0] {
        PH_KEY1    = 6'b000001,
        PH_KEY2    = 6'b000010,
        PH_TYPE    = 6'b000100,
        PH_FIXED   = 6'b001000,
        PH_STRING  = 6'b010000,
        PH_STOPPED = 6'b100000
    } t_phase;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [CNT_W-1:0] len;
        logic [1:0]       status;
        logic             last;
    } t_result;

    // Results caused by one input beat, lowest entry first
    typedef struct packed {
        logic [1:0]                count;
        t_result [MAX_RESULTS-1:0] res;
    } t_step;

    // Payload size for a type byte: string and unknown get their own codes
    function automatic logic [3:0] type_size(input logic [7:0] t);
        logic [3:0] sz;
        sz = SIZE_UNKNOWN;
        case (t) inside
            CH_UA, CH_UC, CH_LC: sz = 4'd1;
            CH_US, CH_LS:        sz = 4'd2;
            CH_UI, CH_LI, CH_LF: sz = 4'd4;
            CH_LD:               sz = 4'd8;
            CH_UZ, CH_UH:        sz = SIZE_STRING;
            default:             sz = SIZE_UNKNOWN;
        endcase
        return sz;
    endfunction

endpackage

>>> src/atsf_parser.sv
module atsf_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [atsf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [atsf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_accept,
    input  logic [7:0]                         i_byte,
    input  logic                               i_end,
    output atsf_pkg::t_step                    o_step
);

    logic [2:0]                                         r_key_count;
    logic [atsf_pkg::NUM_KEY_REGS-1:0][atsf_pkg::KEY_W-1:0] r_keys;

    atsf_pkg::t_phase           r_phase, n_phase;
    logic [7:0]                 r_held, n_held;
    logic                       r_keep, n_keep;
    logic [3:0]                 r_left, n_left;
    logic                       r_err, n_err;
    logic [atsf_pkg::CNT_W-1:0] r_kept, n_kept;

    logic                       match;
    logic [3:0]                 sz;
    logic [3:0]                 left_dec;
    logic [1:0]                 nd;
    logic [7:0]                 d0, d1;
    logic [atsf_pkg::CNT_W:0]   kept_sum;
    logic [atsf_pkg::CNT_W-1:0] kept_after;
    logic [1:0]                 sum_status;
    atsf_pkg::t_result          summary;

    // Compare the key against the active filter keys
    always_comb begin
        match = 1'b0;
        for (int i = 0; i < atsf_pkg::NUM_KEY_REGS; i++) begin
            if ((3'(i) < r_key_count) && (i < atsf_pkg::MAX_FILTER_KEYS) &&
                (r_keys[i] == {r_held, i_byte})) begin
                match = 1'b1;
            end
        end
    end

    assign sz       = atsf_pkg::type_size(i_byte);
    assign left_dec = r_left - 4'd1;

    // Advance the parse for one byte
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_keep  = r_keep;
        n_left  = r_left;
        n_err   = r_err;
        nd      = 2'd0;
        d0      = i_byte;
        d1      = i_byte;
        unique case (r_phase)
            atsf_pkg::PH_KEY1: begin
                n_held  = i_byte;
                n_phase = atsf_pkg::PH_KEY2;
            end
            atsf_pkg::PH_KEY2: begin
                n_keep  = !match;
                n_phase = atsf_pkg::PH_TYPE;
                if (!match) begin
                    nd = 2'd2;
                    d0 = r_held;
                end
            end
            atsf_pkg::PH_TYPE: begin
                if (sz == atsf_pkg::SIZE_UNKNOWN) begin
                    n_err   = 1'b1;
                    n_phase = atsf_pkg::PH_STOPPED;
                end else begin
                    if (r_keep) nd = 2'd1;
                    if (sz == atsf_pkg::SIZE_STRING) begin
                        n_left  = 4'd0;
                        n_phase = atsf_pkg::PH_STRING;
                    end else begin
                        n_left  = sz;
                        n_phase = atsf_pkg::PH_FIXED;
                    end
                end
            end
            atsf_pkg::PH_FIXED: begin
                if (r_keep) nd = 2'd1;
                n_left = left_dec;
                if (left_dec == 4'd0) n_phase = atsf_pkg::PH_KEY1;
            end
            atsf_pkg::PH_STRING: begin
                if (r_keep) nd = 2'd1;
                if (i_byte == 8'd0) n_phase = atsf_pkg::PH_KEY1;
            end
            atsf_pkg::PH_STOPPED: begin
            end
            default: begin
            end
        endcase

        // Saturating kept count after this beat's bytes
        kept_sum   = {1'b0, r_kept} + (atsf_pkg::CNT_W+1)'(nd);
        kept_after = kept_sum[atsf_pkg::CNT_W] ? '1 : kept_sum[atsf_pkg::CNT_W-1:0];
        n_kept     = kept_after;

        if (n_err)                              sum_status = atsf_pkg::ST_UNKNOWN;
        else if (n_phase != atsf_pkg::PH_KEY1)  sum_status = atsf_pkg::ST_TRUNC;
        else                                    sum_status = atsf_pkg::ST_OK;

        // Return all parse state to reset at block end
        if (i_end) begin
            n_phase = atsf_pkg::PH_KEY1;
            n_held  = 8'd0;
            n_keep  = 1'b1;
            n_left  = 4'd0;
            n_err   = 1'b0;
            n_kept  = '0;
        end
    end

    // Build the result list: data bytes first, summary after
    always_comb begin
        summary        = '0;
        summary.kind   = atsf_pkg::KIND_SUMMARY;
        summary.len    = kept_after;
        summary.status = sum_status;

        o_step.count = nd + {1'b0, i_end};
        for (int j = 0; j < atsf_pkg::MAX_RESULTS; j++) begin
            o_step.res[j] = summary;
            if (2'(j) < nd) begin
                o_step.res[j]      = '0;
                o_step.res[j].kind = atsf_pkg::KIND_DATA;
                o_step.res[j].data = (j == 0) ? d0 : d1;
            end
            o_step.res[j].last = (2'(j + 1) == o_step.count);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= atsf_pkg::KEY_COUNT_RST;
            r_keys[0]   <= atsf_pkg::KEY_A_RST;
            r_keys[1]   <= '0;
            r_keys[2]   <= '0;
            r_keys[3]   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                atsf_pkg::CFG_KEY_COUNT: r_key_count <= i_cfg_data[2:0];
                atsf_pkg::CFG_KEY_A:     r_keys[0]   <= i_cfg_data;
                atsf_pkg::CFG_KEY_B:     r_keys[1]   <= i_cfg_data;
                atsf_pkg::CFG_KEY_C:     r_keys[2]   <= i_cfg_data;
                atsf_pkg::CFG_KEY_D:     r_keys[3]   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= atsf_pkg::PH_KEY1;
            r_held  <= 8'd0;
            r_keep  <= 1'b1;
            r_left  <= 4'd0;
            r_err   <= 1'b0;
            r_kept  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_keep  <= n_keep;
            r_left  <= n_left;
            r_err   <= n_err;
            r_kept  <= n_kept;
        end
    end

endmodule

>>> src/aux_tag_stream_filter.sv
// Channel   | Dir | Contents
// s_axis    | in  | tdata[7:0] aux_byte; tlast block_end
// m_axis    | out | tdata[7:0] out_byte, [23:8] kept_length, [25:24] status; tuser item_kind;
//           |     | tlast last_result
// i_cfg     | in  | write enable, index 0 key_count, 1..4 filter_key_a..d
//
// One byte is parsed in the cycle it is taken; its results (up to three) go to a
// three-entry result buffer that drains one beat per cycle while m_axis is ready.
// A new byte is taken whenever the buffer is empty or its final beat leaves in the
// same cycle, so a byte with several results holds off the next byte until they drain.
// Reset is synchronous, active low; it restores the registers and the parse state.
// A stall on m_axis holds the buffer and, while any beat waits, s_axis.
module aux_tag_stream_filter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [atsf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [atsf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [7:0] aux_byte
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] out_byte, [23:8] kept_length, [25:24] status, [31:26] zero
    output logic [atsf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tuser,  // [0] item_kind
    output logic                                 m_axis_tlast
);

    atsf_pkg::t_step                            step;
    atsf_pkg::t_result [atsf_pkg::MAX_RESULTS-1:0] r_buf;
    logic [1:0]                                 r_pend;
    logic                                       s_hs, m_hs;

    assign s_hs = s_axis_tvalid && s_axis_tready;
    assign m_hs = m_axis_tvalid && m_axis_tready;

    atsf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (s_hs),
        .i_byte      (s_axis_tdata),
        .i_end       (s_axis_tlast),
        .o_step      (step)
    );

    // Take a byte when the buffer is empty or its final beat is leaving
    assign s_axis_tready = (r_pend == 2'd0) || ((r_pend == 2'd1) && m_axis_tready);

    // Count pending beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else if (s_hs) begin
            r_pend <= step.count;
        end else if (m_hs) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    // Load a new result list or shift out the sent beat
    always_ff @(posedge i_clk) begin
        if (s_hs) begin
            r_buf <= step.res;
        end else if (m_hs) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    assign m_axis_tvalid = (r_pend != 2'd0);
    assign m_axis_tdata  = {6'd0, r_buf[0].status, r_buf[0].len, r_buf[0].data};
    assign m_axis_tuser  = r_buf[0].kind;
    assign m_axis_tlast  = r_buf[0].last;

    // No byte is taken while two or more beats still wait
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend >= 2'd2) |-> !s_axis_tready)
        else $error("byte taken while result buffer busy");

    // Sending the final pending beat with no new byte empties the buffer
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_hs && (r_pend == 2'd1) && !s_hs) |=> (r_pend == 2'd0))
        else $error("result buffer did not drain");

    // A summary beat always closes the results of its byte
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == atsf_pkg::KIND_SUMMARY)) |-> m_axis_tlast)
        else $error("summary beat without tlast");

    // The last pending beat carries tlast
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd1) |-> m_axis_tlast)
        else $error("final beat of a byte lacks tlast");

endmodule

>>> verif/atsf_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams, tracks the tag parser and
// compares every output beat with the oldest predicted one.
module atsf_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [atsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [atsf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [7:0]                       i_s_tdata,
    input  logic                             i_s_tlast,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [atsf_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                             i_m_tuser,
    input  logic                             i_m_tlast,
    output int                               o_pending,
    output int                               o_mismatches
);

    // payload_len codes: 0 is an unknown type
    localparam int STRING_PAYLOAD = -1;

    // Shadow registers
    logic [2:0]                 key_cnt;
    logic [atsf_pkg::KEY_W-1:0] drop_key [atsf_pkg::NUM_KEY_REGS];

    // Parser state
    atsf_pkg::t_phase           phase;
    logic [7:0]                 held_byte;
    logic                       keep_rec;
    logic [3:0]                 fixed_left;
    logic                       err_seen;
    logic [atsf_pkg::CNT_W-1:0] kept_bytes;

    atsf_pkg::t_result want_q [$];
    int                mismatches = 0;

    function automatic int payload_len(input logic [7:0] t);
        case (t)
            atsf_pkg::CH_UA, atsf_pkg::CH_UC, atsf_pkg::CH_LC: return 1;
            atsf_pkg::CH_US, atsf_pkg::CH_LS:                  return 2;
            atsf_pkg::CH_UI, atsf_pkg::CH_LI, atsf_pkg::CH_LF: return 4;
            atsf_pkg::CH_LD:                                   return 8;
            atsf_pkg::CH_UZ, atsf_pkg::CH_UH:                  return STRING_PAYLOAD;
            default:                                           return 0;
        endcase
    endfunction

    // Only the first key_cnt keys take part, never more than exist
    function automatic logic key_dropped(input logic [atsf_pkg::KEY_W-1:0] key);
        int   n;
        logic hit;
        n = int'(key_cnt);
        if (n > atsf_pkg::MAX_FILTER_KEYS) n = atsf_pkg::MAX_FILTER_KEYS;
        if (n > atsf_pkg::NUM_KEY_REGS) n = atsf_pkg::NUM_KEY_REGS;
        hit = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (drop_key[i] == key) hit = 1'b1;
        end
        return hit;
    endfunction

    // Build a data beat and bump the saturating kept length
    function automatic atsf_pkg::t_result data_beat(input logic [7:0] b);
        atsf_pkg::t_result r;
        r      = '0;
        r.kind = atsf_pkg::KIND_DATA;
        r.data = b;
        if (kept_bytes != '1) kept_bytes++;
        return r;
    endfunction

    task automatic restart_parse();
        phase      = atsf_pkg::PH_KEY1;
        held_byte  = '0;
        keep_rec   = 1'b1;
        fixed_left = '0;
        err_seen   = 1'b0;
        kept_bytes = '0;
    endtask

    // Advance the parser by one input byte and queue the beats it causes
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        atsf_pkg::t_result res [$];
        atsf_pkg::t_result sum;
        atsf_pkg::t_result tail;
        int                sz;
        case (phase)
            atsf_pkg::PH_KEY1: begin
                held_byte = b;
                phase     = atsf_pkg::PH_KEY2;
            end
            atsf_pkg::PH_KEY2: begin
                keep_rec = !key_dropped({held_byte, b});
                if (keep_rec) begin
                    res.push_back(data_beat(held_byte));
                    res.push_back(data_beat(b));
                end
                phase = atsf_pkg::PH_TYPE;
            end
            atsf_pkg::PH_TYPE: begin
                sz = payload_len(b);
                if (sz == 0) begin
                    err_seen = 1'b1;
                    phase    = atsf_pkg::PH_STOPPED;
                end else begin
                    if (keep_rec) res.push_back(data_beat(b));
                    if (sz == STRING_PAYLOAD) begin
                        fixed_left = '0;
                        phase      = atsf_pkg::PH_STRING;
                    end else begin
                        fixed_left = 4'(sz);
                        phase      = atsf_pkg::PH_FIXED;
                    end
                end
            end
            atsf_pkg::PH_FIXED: begin
                if (keep_rec) res.push_back(data_beat(b));
                fixed_left = fixed_left - 4'd1;
                if (fixed_left == '0) phase = atsf_pkg::PH_KEY1;
            end
            atsf_pkg::PH_STRING: begin
                if (keep_rec) res.push_back(data_beat(b));
                if (b == 8'h00) phase = atsf_pkg::PH_KEY1;
            end
            default: ; // drop everything after an unknown type
        endcase

        // Close the block with its summary and start over
        if (fin) begin
            sum        = '0;
            sum.kind   = atsf_pkg::KIND_SUMMARY;
            sum.len    = kept_bytes;
            if (err_seen) sum.status = atsf_pkg::ST_UNKNOWN;
            else if (phase != atsf_pkg::PH_KEY1) sum.status = atsf_pkg::ST_TRUNC;
            else sum.status = atsf_pkg::ST_OK;
            res.push_back(sum);
            restart_parse();
        end

        if (res.size() > 0) begin
            tail      = res.pop_back();
            tail.last = 1'b1;
            res.push_back(tail);
        end
        foreach (res[i]) want_q.push_back(res[i]);
    endtask

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] exp);
        mismatches++;
        $display("%0t: %s got 0x%0h, expected 0x%0h", $time, field, got, exp);
    endtask

    task automatic compare_beat();
        atsf_pkg::t_result w;
        if (want_q.size() == 0) begin
            report("beat with nothing pending", i_m_tdata, 32'd0);
        end else begin
            w = want_q.pop_front();
            if (i_m_tuser !== w.kind)
                report("item_kind", 32'(i_m_tuser), 32'(w.kind));
            if (i_m_tdata[7:0] !== w.data)
                report("out_byte", 32'(i_m_tdata[7:0]), 32'(w.data));
            if (i_m_tdata[23:8] !== w.len)
                report("kept_length", 32'(i_m_tdata[23:8]), 32'(w.len));
            if (i_m_tdata[25:24] !== w.status)
                report("status", 32'(i_m_tdata[25:24]), 32'(w.status));
            if (i_m_tdata[31:26] !== '0)
                report("tdata padding", 32'(i_m_tdata[31:26]), 32'd0);
            if (i_m_tlast !== w.last)
                report("last_result", 32'(i_m_tlast), 32'(w.last));
        end
    endtask

    // Predict on accepted input beats, then check accepted output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_cnt     = atsf_pkg::KEY_COUNT_RST;
            drop_key[0] = atsf_pkg::KEY_A_RST;
            drop_key[1] = '0;
            drop_key[2] = '0;
            drop_key[3] = '0;
            restart_parse();
            want_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    atsf_pkg::CFG_KEY_COUNT: key_cnt     = i_cfg_data[2:0];
                    atsf_pkg::CFG_KEY_A:     drop_key[0] = i_cfg_data;
                    atsf_pkg::CFG_KEY_B:     drop_key[1] = i_cfg_data;
                    atsf_pkg::CFG_KEY_C:     drop_key[2] = i_cfg_data;
                    atsf_pkg::CFG_KEY_D:     drop_key[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) absorb_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) compare_beat();
        end
        o_pending    <= want_q.size();
        o_mismatches <= mismatches;
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Feeds tag blocks to the filter under several key settings; the checker
// beside the block does all prediction and comparison.
module testbench;

    localparam int LIMIT       = 1_000_000;
    localparam int LONG_HOLD   = 200;
    localparam int PHASE_ITEMS = 22;
    localparam int LONG_STRING = 12;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             cfg_we   = 1'b0;
    logic [atsf_pkg::CFG_IDX_W-1:0]   cfg_idx  = '0;
    logic [atsf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata  = '0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [atsf_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tuser;
    logic                             m_tlast;

    int n_pending;
    int n_fail;
    int cycles = 0;

    // Sender pacing
    int burst_left = 0;
    bit steady     = 1'b0;

    // Receiver pacing
    logic hold_req    = 1'b0;
    bit   rx_held_off = 1'b0;
    int   rx_mode     = 0;
    int   rx_left     = 0;
    int   rx_k;

    // Block under construction and stimulus bookkeeping
    logic [7:0]                 blk [$];
    logic [atsf_pkg::KEY_W-1:0] drop_pool [atsf_pkg::NUM_KEY_REGS];
    int                         type_turn = 0;

    localparam logic [atsf_pkg::CFG_IDX_W-1:0] KEY_IDX [atsf_pkg::NUM_KEY_REGS] =
        '{atsf_pkg::CFG_KEY_A, atsf_pkg::CFG_KEY_B, atsf_pkg::CFG_KEY_C,
          atsf_pkg::CFG_KEY_D};
    logic [7:0] type_set [11] =
        '{atsf_pkg::CH_UA, atsf_pkg::CH_UC, atsf_pkg::CH_LC, atsf_pkg::CH_US,
          atsf_pkg::CH_LS, atsf_pkg::CH_UI, atsf_pkg::CH_LI, atsf_pkg::CH_LF,
          atsf_pkg::CH_LD, atsf_pkg::CH_UZ, atsf_pkg::CH_UH};
    // payload bytes per type, 0 for a string
    int type_bytes [11] = '{1, 1, 1, 2, 2, 4, 4, 4, 8, 0, 0};

    aux_tag_stream_filter u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    atsf_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_pending    (n_pending),
        .o_mismatches (n_fail)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Give up after a generous number of cycles
    initial begin
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("aux_tag_stream_filter: mismatch");
        $finish;
    end

    // Receiver: switch between stall patterns, and hold off once on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && !rx_held_off) begin
                rx_held_off = 1'b1;
                m_tready <= 1'b0;
                for (rx_k = 1; rx_k < LONG_HOLD; rx_k++) @(posedge clk);
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(8, 60);
                end
                rx_left--;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    function automatic bit known_type(input logic [7:0] t);
        foreach (type_set[i]) begin
            if (type_set[i] == t) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one beat, inserting a random gap at the start of each burst
    task automatic put_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_block();
        foreach (blk[i]) put_byte(blk[i], i == blk.size() - 1);
    endtask

    // Stop offering and wait until every predicted beat has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [atsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_key(input int n, input logic [atsf_pkg::KEY_W-1:0] val);
        drop_pool[n] = val;
        write_reg(KEY_IDX[n], val);
    endtask

    // Append one record; a bad one carries an unknown type and some junk
    task automatic add_record(input bit bad);
        logic [atsf_pkg::KEY_W-1:0] key;
        logic [7:0]                 t;
        int                         i;
        int                         len;
        if ($urandom_range(0, 9) < 4)
            key = drop_pool[$urandom_range(0, atsf_pkg::NUM_KEY_REGS - 1)];
        else key = 16'($urandom_range(0, 65535));
        blk.push_back(key[15:8]);
        blk.push_back(key[7:0]);
        if (bad) begin
            do t = 8'($urandom_range(0, 255)); while (known_type(t));
            blk.push_back(t);
            len = $urandom_range(0, 3);
            repeat (len) blk.push_back(8'($urandom_range(0, 255)));
        end else begin
            // walk through every type once before picking at random
            i = (type_turn < 11) ? type_turn : $urandom_range(0, 10);
            type_turn++;
            blk.push_back(type_set[i]);
            if (type_bytes[i] == 0) begin
                len = $urandom_range(0, 6);
                repeat (len) blk.push_back(8'($urandom_range(1, 255)));
                blk.push_back(8'h00);
            end else begin
                repeat (type_bytes[i]) blk.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Mostly well-formed blocks, plus bad types, truncation and raw noise
    task automatic random_block();
        int r;
        int n;
        int cut;
        blk.delete();
        r = $urandom_range(0, 9);
        if (r < 7) begin
            n = $urandom_range(1, 4);
            repeat (n) add_record(1'b0);
        end else if (r == 7) begin
            n = $urandom_range(0, 2);
            repeat (n) add_record(1'b0);
            add_record(1'b1);
        end else if (r == 8) begin
            n = $urandom_range(1, 3);
            repeat (n) add_record(1'b0);
            cut = $urandom_range(1, blk.size() - 1);
            while (blk.size() > cut) void'(blk.pop_back());
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) blk.push_back(8'($urandom_range(0, 255)));
        end
        send_block();
    endtask

    task automatic random_phase(input int quota, input bit pressure);
        int sent;
        bit asked;
        bit paused;
        sent   = 0;
        asked  = 1'b0;
        paused = 1'b0;
        while (sent < quota) begin
            // hold the receiver off while the first blocks are offered
            if (pressure && !asked) begin
                asked = 1'b1;
                hold_req <= 1'b1;
            end
            if (pressure && !paused && sent >= 12) begin
                paused = 1'b1;
                drain();
            end
            random_block();
            sent += blk.size();
        end
    endtask

    initial begin
        drop_pool[0] = atsf_pkg::KEY_A_RST;
        drop_pool[1] = '0;
        drop_pool[2] = '0;
        drop_pool[3] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed blocks under the reset keys
        blk = '{8'h52, 8'h47, atsf_pkg::CH_UA, 8'hFF};      // dropped record
        send_block();
        blk = '{8'h58, 8'h59};                              // block ends on a kept key
        send_block();
        blk = '{8'h4E, 8'h4D, atsf_pkg::CH_UZ, 8'h00};      // empty string
        send_block();
        blk = '{8'h00, 8'hFF, 8'h71, 8'h12};                // unknown type
        send_block();
        blk = '{8'h61, 8'h62, atsf_pkg::CH_LD, 8'h00, 8'hFF}; // truncated payload
        send_block();
        blk = '{8'hFF};                                     // lone byte
        send_block();

        random_phase(PHASE_ITEMS, 1'b1);
        drain();

        // All four keys active, extreme key values
        write_reg(atsf_pkg::CFG_KEY_COUNT, 16'd4);
        set_key(0, 16'h0000);
        set_key(1, 16'hFFFF);
        set_key(2, 16'($urandom_range(0, 65535)));
        set_key(3, 16'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
        random_phase(PHASE_ITEMS, 1'b0);
        drain();

        // No keys active: everything kept, one string sent back to back
        write_reg(atsf_pkg::CFG_KEY_COUNT, 16'd0);
        cfg_we <= 1'b0;
        blk.delete();
        blk.push_back(8'h4C);
        blk.push_back(8'h53);
        blk.push_back(atsf_pkg::CH_UZ);
        repeat (LONG_STRING) blk.push_back(8'($urandom_range(1, 255)));
        blk.push_back(8'h00);
        blk.push_back(8'h41);
        blk.push_back(8'h42);
        blk.push_back(atsf_pkg::CH_UC);
        blk.push_back(8'h55);
        steady = 1'b1;
        send_block();
        steady = 1'b0;
        blk.delete();
        random_phase(PHASE_ITEMS, 1'b0);
        drain();

        // Count above the number of keys acts as all four
        write_reg(atsf_pkg::CFG_KEY_COUNT, 16'd7);
        set_key(0, 16'($urandom_range(0, 65535)));
        set_key(3, 16'h5247);
        cfg_we <= 1'b0;
        random_phase(PHASE_ITEMS, 1'b0);
        drain();

        // Two active keys; the others must not drop anything
        write_reg(atsf_pkg::CFG_KEY_COUNT, 16'd2);
        set_key(1, 16'($urandom_range(0, 65535)));
        set_key(2, 16'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
        random_phase(PHASE_ITEMS, 1'b0);
        drain();

        if (n_fail == 0) begin
            $display("aux_tag_stream_filter: match");
        end else begin
            $display("aux_tag_stream_filter: mismatch");
        end
        $finish;
    end

endmodule
